// ----- src/imft_pkg.sv -----
// Shared types, codes and helpers for the IPv4 mask filter table.
package imft_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 1024;
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 32;
    localparam int MASK_W  = 4;
    localparam int STAT_W  = 2;
    localparam int LIVE_W  = 11;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [MASK_W-1:0] mask;
        logic [ADDR_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    function automatic logic [ADDR_W-1:0] octet_bits(input logic [MASK_W-1:0] m);
        logic [ADDR_W-1:0] bits;
        bits = '0;
        for (int k = 0; k < MASK_W; k++) begin
            if (m[k]) begin
                bits[8*k +: 8] = 8'hFF;
            end
        end
        return bits;
    endfunction

endpackage

// ----- src/imft_store.sv -----
// Filter entry memory: one write port, one registered read port.
module imft_store
    import imft_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_ENTRIES,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_t           rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/imft_match.sv -----
// Shared entry compare unit used on every scan beat.
module imft_match
    import imft_pkg::*;
(
    input  logic [CMD_W-1:0]  cmd,
    input  logic [ADDR_W-1:0] address,
    input  logic [MASK_W-1:0] mask,
    input  logic [ADDR_W-1:0] value,
    input  entry_t            entry,
    output logic              hit
);

    always_comb begin
        case (cmd)
            CMD_CHECK:  hit = entry.valid &&
                              ((address & octet_bits(entry.mask)) == entry.value);
            CMD_ADD:    hit = !entry.valid;
            CMD_REMOVE: hit = entry.valid && (entry.mask == mask) && (entry.value == value);
            default:    hit = 1'b0;
        endcase
    end

endmodule

// ----- src/ip_mask_filter_table_core.sv -----
// Top level of the IPv4 octet mask filter table with scan sequencer.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_tvalid / s_tready  | s_tuser command, s_tdata address,
//          |           |                      |   filter value, octet mask
//  m_      | out       | m_tvalid / m_tready  | m_tdata blocked, status, live entries
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_data ban mode
//
// A check, add or remove reads the stored entries one per cycle through the single
// memory read port, up to the high-water mark, and stops at the first matching entry.
// A reserved command skips the scan. The input is not ready until the item finishes.
// Reset clears counters and ban mode to 1; the memory needs no clearing pass.
// A stalled result holds in the output register while the next item is accepted.
module ip_mask_filter_table_core
    import imft_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // address[31:0], filter_value[63:32],
                                          // filter_octet_mask[67:64], zero[71:68]
    input  logic [CMD_W-1:0]    s_tuser,  // command[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // blocked[0], status[2:1],
                                          // live_entries[13:3], zero[15:14]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ENTRIES);

    state_t state_reg, state_next;

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] fval_reg, fval_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  found_idx_reg, found_idx_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic              ban_mode_reg, ban_mode_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              out_blocked_reg, out_blocked_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [LIVE_W-1:0] out_live_reg, out_live_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    logic             hit;
    logic             slot_free;
    logic             scan_more;
    logic             in_beat;

    imft_store #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    imft_match u_match (
        .cmd     (cmd_reg),
        .address (addr_reg),
        .mask    (mask_reg),
        .value   (fval_reg),
        .entry   (rd_data),
        .hit     (hit)
    );

    assign slot_free = !m_tvalid_reg || m_tready;
    assign scan_more = scan_reg < used_reg;
    assign in_beat   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == CMD_RSVD) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((pend_reg && hit) || (!pend_reg && !scan_more)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready         = 1'b0;
        rd_en            = 1'b0;
        rd_idx           = scan_reg[IDX_W-1:0];
        wr_en            = 1'b0;
        wr_idx           = found_idx_reg;
        wr_data          = '{valid: 1'b1, mask: mask_reg, value: fval_reg};
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        fval_next        = fval_reg;
        mask_next        = mask_reg;
        scan_next        = scan_reg;
        pend_next        = 1'b0;
        pend_idx_next    = scan_reg[IDX_W-1:0];
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        used_next        = used_reg;
        live_next        = live_reg;
        out_blocked_next = out_blocked_reg;
        out_status_next  = out_status_reg;
        out_live_next    = out_live_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        ban_mode_next    = (cfg_valid && cfg_ready) ? cfg_data : ban_mode_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_beat) begin
                    cmd_next   = s_tuser;
                    addr_next  = s_tdata[ADDR_W-1:0];
                    mask_next  = s_tdata[2*ADDR_W +: MASK_W];
                    fval_next  = s_tdata[ADDR_W +: ADDR_W] &
                                 octet_bits(s_tdata[2*ADDR_W +: MASK_W]);
                    scan_next  = '0;
                    found_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (pend_reg && hit) begin
                    found_next     = 1'b1;
                    found_idx_next = pend_idx_reg;
                end else if (scan_more) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    m_tvalid_next    = 1'b1;
                    out_blocked_next = 1'b0;
                    out_status_next  = STAT_DONE;
                    case (cmd_reg)
                        CMD_CHECK: begin
                            out_blocked_next = found_reg ? ban_mode_reg : !ban_mode_reg;
                        end
                        CMD_ADD: begin
                            if (found_reg) begin
                                wr_en     = 1'b1;
                                live_next = live_reg + 1'b1;
                            end else if (used_reg == CAP) begin
                                out_status_next = STAT_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_idx    = used_reg[IDX_W-1:0];
                                used_next = used_reg + 1'b1;
                                live_next = live_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (found_reg) begin
                                wr_en         = 1'b1;
                                wr_data.valid = 1'b0;
                                if (live_reg != '0) begin
                                    live_next = live_reg - 1'b1;
                                end
                            end else begin
                                out_status_next = STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                            out_status_next = STAT_DONE;
                        end
                    endcase
                    out_live_next = LIVE_W'(live_next);
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            used_reg     <= '0;
            live_reg     <= '0;
            ban_mode_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
            scan_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            used_reg     <= used_next;
            live_reg     <= live_next;
            ban_mode_reg <= ban_mode_next;
            m_tvalid_reg <= m_tvalid_next;
            scan_reg     <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        addr_reg        <= addr_next;
        fval_reg        <= fval_next;
        mask_reg        <= mask_next;
        pend_idx_reg    <= pend_idx_next;
        found_idx_reg   <= found_idx_next;
        out_blocked_reg <= out_blocked_next;
        out_status_reg  <= out_status_next;
        out_live_reg    <= out_live_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, out_live_reg, out_status_reg, out_blocked_reg};

endmodule

// ----- src/imft_check.sv -----
// Port-level checker for the filter table core, bound to the top level.
module imft_check
    import imft_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    property p_out_reset;
        @(posedge aclk) !aresetn |=> !m_tvalid;
    endproperty
    a_out_reset: assert property (p_out_reset)
        else $error("result valid right after reset");

    property p_busy_after_beat;
        @(posedge aclk) disable iff (!aresetn)
            (s_tvalid && s_tready) |=> !s_tready;
    endproperty
    a_busy_after_beat: assert property (p_busy_after_beat)
        else $error("input ready again right after a beat");

    property p_blocked_done;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tdata[0]) |-> (m_tdata[2:1] == STAT_DONE);
    endproperty
    a_blocked_done: assert property (p_blocked_done)
        else $error("blocked result with non-done status");

    property p_hold_stalled;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
    endproperty
    a_hold_stalled: assert property (p_hold_stalled)
        else $error("stalled result beat changed");

endmodule

bind ip_mask_filter_table_core imft_check u_imft_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
